// ===== hdl/tlp_pkg.sv =====
// Shared types, constants and character tables for the request line parser.
// Used by tlp_in_stage, tlp_parser and text_request_line_parser.
package tlp_pkg;

   // sizing
   localparam int MAX_PATH = 2048;
   localparam int NUM_BITS = 31;
   localparam int ACC_W    = NUM_BITS;
   localparam int SUM_W    = ACC_W + 4;
   localparam int PATH_W   = $clog2(MAX_PATH);
   localparam int RANGE_W  = 31;
   localparam int KW_LEN   = 12;
   localparam int RW_LEN   = 6;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 80;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BAD    = 2'd1;
   localparam logic [1:0] ST_CLOSED = 2'd2;

   // result kinds
   localparam logic KIND_PATH   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // register indexes
   localparam logic CSR_LOCAL_ADDRESS = 1'b0;
   localparam logic CSR_LOCAL_PORT    = 1'b1;

   localparam logic [31:0] LOCAL_ADDRESS_RESET = 32'h7F00_0001;
   localparam logic [15:0] LOCAL_PORT_RESET    = 16'd55555;

   // characters
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_NINE  = "9";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_COLON = ":";
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_DASH  = "-";
   localparam logic [7:0] CH_G     = "G";
   localparam logic [7:0] CH_I     = "I";
   localparam logic [7:0] CH_R     = "R";

   localparam logic [7:0] KW_GET [KW_LEN] =
      '{"G", "E", "T", " ", "m", "h", "t", "t", "p", ":", "/", "/"};
   localparam logic [7:0] KW_INF [KW_LEN] =
      '{"I", "N", "F", " ", "m", "h", "t", "t", "p", ":", "/", "/"};
   localparam logic [7:0] RANGE_WORD [RW_LEN] = '{"R", "a", "n", "g", "e", " "};

   // one request byte
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       peer_closed;
   } req_beat_type;

   // one result item
   typedef struct packed {
      logic               kind;
      logic [7:0]         path_byte;
      logic [1:0]         status;
      logic               req_type;
      logic               range_given;
      logic [RANGE_W-1:0] range_first;
      logic               last_given;
      logic [RANGE_W-1:0] range_last;
   } rsp_beat_type;

endpackage

// ===== hdl/tlp_in_stage.sv =====
// Input register stage of the request line parser: holds one request beat.
// Depends on tlp_pkg for the beat type.
module tlp_in_stage
   import tlp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] rx_byte
   input  logic                   req_tuser,   // [0] peer_closed
   output logic                   out_valid,
   input  logic                   out_ready,
   output req_beat_type           out_beat
);

   logic         valid_ff;
   req_beat_type beat_ff;

   // take a new beat when empty or when the held one moves on
   assign req_tready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         beat_ff.rx_byte     <= req_tdata[7:0];
         beat_ff.peer_closed <= req_tuser;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

// ===== hdl/tlp_parser.sv =====
// Grammar state machine and result register of the request line parser.
// Depends on tlp_pkg for types, character tables and sizing constants.
module tlp_parser
   import tlp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_beat_type in_beat,
   input  logic [31:0]  local_address,
   input  logic [15:0]  local_port,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_beat
);

   // parse phases
   localparam logic [3:0] PH_KEYWORD    = 4'd0;
   localparam logic [3:0] PH_OCTET      = 4'd1;
   localparam logic [3:0] PH_PORT       = 4'd2;
   localparam logic [3:0] PH_PATH       = 4'd3;
   localparam logic [3:0] PH_AFTER_PATH = 4'd4;
   localparam logic [3:0] PH_RANGE_WORD = 4'd5;
   localparam logic [3:0] PH_FIRST      = 4'd6;
   localparam logic [3:0] PH_AFTER_DASH = 4'd7;
   localparam logic [3:0] PH_LAST       = 4'd8;
   localparam logic [3:0] PH_BLANK      = 4'd9;

   localparam logic [SUM_W-1:0] LIMIT_OCTET = SUM_W'(255);
   localparam logic [SUM_W-1:0] LIMIT_PORT  = SUM_W'(65535);
   localparam logic [SUM_W-1:0] LIMIT_RANGE = {4'b0, {ACC_W{1'b1}}};

   logic [3:0]        phase_ff, phase_in;
   logic [3:0]        match_ff, match_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              have_digit_ff, have_digit_in;
   logic [1:0]        octet_ff, octet_in;
   logic [23:0]       addr_ff, addr_in;
   logic [PATH_W-1:0] path_cnt_ff, path_cnt_in;
   logic              type_ff, type_in;
   logic [ACC_W-1:0]  first_ff, first_in;
   logic [1:0]        flags_ff, flags_in;

   logic              rsp_valid_ff;
   rsp_beat_type      rsp_ff;
   rsp_beat_type      rsp_in;
   logic              emit;
   logic              go;

   // shared decimal digit step
   logic [7:0]        rx;
   logic [7:0]        digit_raw;
   logic              is_digit;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  limit;
   logic              digit_ok;
   logic [31:0]       addr_full;

   assign rx        = in_beat.rx_byte;
   assign digit_raw = rx - CH_ZERO;
   assign is_digit  = (rx >= CH_ZERO) && (rx <= CH_NINE);
   assign sum       = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + SUM_W'(digit_raw[3:0]);
   assign addr_full = {addr_ff, acc_ff[7:0]};

   always_comb begin
      unique case (phase_ff)
         PH_OCTET: limit = LIMIT_OCTET;
         PH_PORT:  limit = LIMIT_PORT;
         default:  limit = LIMIT_RANGE;
      endcase
   end

   // no leading zero and no overflow past the field limit
   assign digit_ok = !(have_digit_ff && (acc_ff == '0)) && (sum <= limit);

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign go       = in_valid && in_ready;

   // next state and result for one beat
   always_comb begin
      logic       fin;
      logic [1:0] fin_status;
      logic       fin_ok;

      phase_in      = phase_ff;
      match_in      = match_ff;
      acc_in        = acc_ff;
      have_digit_in = have_digit_ff;
      octet_in      = octet_ff;
      addr_in       = addr_ff;
      path_cnt_in   = path_cnt_ff;
      type_in       = type_ff;
      first_in      = first_ff;
      flags_in      = flags_ff;
      fin           = 1'b0;
      fin_status    = ST_OK;
      emit          = 1'b0;

      rsp_in.kind        = KIND_PATH;
      rsp_in.path_byte   = rx;
      rsp_in.status      = ST_OK;
      rsp_in.req_type    = type_ff;
      rsp_in.range_given = 1'b0;
      rsp_in.range_first = '0;
      rsp_in.last_given  = 1'b0;
      rsp_in.range_last  = '0;

      if (in_beat.peer_closed) begin
         fin        = 1'b1;
         fin_status = ST_CLOSED;
      end else begin
         unique case (phase_ff)
            PH_KEYWORD: begin
               if (match_ff == '0) begin
                  priority if (rx == CH_G) begin
                     type_in = 1'b0;
                  end else if (rx == CH_I) begin
                     type_in = 1'b1;
                  end else begin
                     fin        = 1'b1;
                     fin_status = ST_BAD;
                  end
               end else if (rx != (type_ff ? KW_INF[match_ff] : KW_GET[match_ff])) begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end
               if (match_ff == 4'(KW_LEN - 1)) begin
                  phase_in = PH_OCTET;
                  match_in = '0;
               end else begin
                  match_in = match_ff + 4'd1;
               end
            end
            PH_OCTET: begin
               priority if (is_digit) begin
                  if (digit_ok) begin
                     acc_in        = sum[ACC_W-1:0];
                     have_digit_in = 1'b1;
                  end else begin
                     fin        = 1'b1;
                     fin_status = ST_BAD;
                  end
               end else if (!have_digit_ff) begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end else if (octet_ff != 2'd3) begin
                  if (rx != CH_DOT) begin
                     fin        = 1'b1;
                     fin_status = ST_BAD;
                  end
                  addr_in       = addr_full[23:0];
                  octet_in      = octet_ff + 2'd1;
                  acc_in        = '0;
                  have_digit_in = 1'b0;
               end else begin
                  // fourth octet closes the address
                  if ((rx != CH_COLON) || (addr_full != local_address)) begin
                     fin        = 1'b1;
                     fin_status = ST_BAD;
                  end
                  phase_in      = PH_PORT;
                  acc_in        = '0;
                  have_digit_in = 1'b0;
               end
            end
            PH_PORT: begin
               priority if (is_digit) begin
                  if (digit_ok) begin
                     acc_in        = sum[ACC_W-1:0];
                     have_digit_in = 1'b1;
                  end else begin
                     fin        = 1'b1;
                     fin_status = ST_BAD;
                  end
               end else if (!have_digit_ff || (rx != CH_SLASH) ||
                            (acc_ff != ACC_W'(local_port))) begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end else begin
                  acc_in        = '0;
                  have_digit_in = 1'b0;
                  path_cnt_in   = '0;
                  phase_in      = PH_PATH;
               end
            end
            PH_PATH: begin
               priority if (rx == CH_NL) begin
                  phase_in = PH_AFTER_PATH;
               end else if (path_cnt_ff >= PATH_W'(MAX_PATH - 1)) begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end else begin
                  path_cnt_in = path_cnt_ff + 1'b1;
                  emit        = 1'b1;
               end
            end
            PH_AFTER_PATH: begin
               priority if (rx == CH_NL) begin
                  fin = 1'b1;
               end else if (!type_ff && (rx == CH_R)) begin
                  match_in = 4'd1;
                  phase_in = PH_RANGE_WORD;
               end else begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end
            end
            PH_RANGE_WORD: begin
               if (rx != RANGE_WORD[match_ff[2:0]]) begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end
               if (match_ff == 4'(RW_LEN - 1)) begin
                  match_in      = '0;
                  phase_in      = PH_FIRST;
                  acc_in        = '0;
                  have_digit_in = 1'b0;
               end else begin
                  match_in = match_ff + 4'd1;
               end
            end
            PH_FIRST: begin
               priority if (is_digit) begin
                  if (digit_ok) begin
                     acc_in        = sum[ACC_W-1:0];
                     have_digit_in = 1'b1;
                  end else begin
                     fin        = 1'b1;
                     fin_status = ST_BAD;
                  end
               end else if (!have_digit_ff || (rx != CH_DASH)) begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end else begin
                  first_in      = acc_ff;
                  acc_in        = '0;
                  have_digit_in = 1'b0;
                  phase_in      = PH_AFTER_DASH;
               end
            end
            PH_AFTER_DASH: begin
               priority if (rx == CH_NL) begin
                  flags_in = 2'b01;
                  phase_in = PH_BLANK;
               end else if (!is_digit || !digit_ok) begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end else begin
                  acc_in        = sum[ACC_W-1:0];
                  have_digit_in = 1'b1;
                  phase_in      = PH_LAST;
               end
            end
            PH_LAST: begin
               priority if (is_digit) begin
                  if (digit_ok) begin
                     acc_in        = sum[ACC_W-1:0];
                     have_digit_in = 1'b1;
                  end else begin
                     fin        = 1'b1;
                     fin_status = ST_BAD;
                  end
               end else if (rx != CH_NL) begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end else begin
                  flags_in = 2'b11;
                  phase_in = PH_BLANK;
               end
            end
            PH_BLANK: begin
               fin        = 1'b1;
               fin_status = (rx == CH_NL) ? ST_OK : ST_BAD;
            end
            default: begin
               fin        = 1'b1;
               fin_status = ST_BAD;
            end
         endcase
      end

      // finishing result, then back to the start of a request
      if (fin) begin
         fin_ok             = (fin_status == ST_OK);
         emit               = 1'b1;
         rsp_in.kind        = KIND_FINISH;
         rsp_in.path_byte   = '0;
         rsp_in.status      = fin_status;
         rsp_in.req_type    = type_ff;
         rsp_in.range_given = fin_ok && flags_ff[0];
         rsp_in.range_first = (fin_ok && flags_ff[0]) ? RANGE_W'(first_ff) : '0;
         rsp_in.last_given  = fin_ok && flags_ff[1];
         rsp_in.range_last  = (fin_ok && flags_ff[1]) ? RANGE_W'(acc_ff) : '0;

         phase_in      = PH_KEYWORD;
         match_in      = '0;
         acc_in        = '0;
         have_digit_in = 1'b0;
         octet_in      = '0;
         addr_in       = '0;
         path_cnt_in   = '0;
         type_in       = 1'b0;
         first_in      = '0;
         flags_in      = '0;
      end else begin
         fin_ok = 1'b0;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_KEYWORD;
         match_ff      <= '0;
         acc_ff        <= '0;
         have_digit_ff <= 1'b0;
         octet_ff      <= '0;
         addr_ff       <= '0;
         path_cnt_ff   <= '0;
         type_ff       <= 1'b0;
         first_ff      <= '0;
         flags_ff      <= '0;
      end else if (go) begin
         phase_ff      <= phase_in;
         match_ff      <= match_in;
         acc_ff        <= acc_in;
         have_digit_ff <= have_digit_in;
         octet_ff      <= octet_in;
         addr_ff       <= addr_in;
         path_cnt_ff   <= path_cnt_in;
         type_ff       <= type_in;
         first_ff      <= first_in;
         flags_ff      <= flags_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

// ===== hdl/text_request_line_parser.sv =====
// Top level of the request line parser: input stage, parser and local registers.
// Depends on tlp_pkg, tlp_in_stage and tlp_parser.

// Checks a text request one byte per beat: a GET or INF keyword, a dotted
// IPv4 address and port that must match csr register 0 (address, first
// octet in the top byte) and csr register 1 (port), a slash, the path, a
// newline, an optional Range line for GET and a closing blank line. Each path
// byte comes out as its own beat (tuser 0); the end of a request, a grammar
// error or a closed connection gives one finishing beat (tuser 1) with the
// status, request type and range, after which parsing starts over. The block
// takes one byte every cycle while the result side is not stalled; a byte passes
// an input register and then the result register before its result beat appears.
// Write the csr registers only while no request is in flight.
module text_request_line_parser
   import tlp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] rx_byte
   input  logic                   req_tuser,   // [0] peer_closed
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // path_byte, status, req_type,
                                               // range_given, range_first,
                                               // last_given, range_last, zeros
   output logic                   rsp_tuser,   // [0] kind
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [31:0]            csr_wdata
);

   logic         stage_valid;
   logic         stage_ready;
   req_beat_type stage_beat;
   rsp_beat_type rsp_beat;
   logic [31:0]  local_address_ff;
   logic [15:0]  local_port_ff;

   // local address and port registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= LOCAL_ADDRESS_RESET;
         local_port_ff    <= LOCAL_PORT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCAL_ADDRESS: local_address_ff <= csr_wdata;
            CSR_LOCAL_PORT:    local_port_ff    <= csr_wdata[15:0];
            default:           local_port_ff    <= local_port_ff;
         endcase
      end
   end

   tlp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_valid  (stage_valid),
      .out_ready  (stage_ready),
      .out_beat   (stage_beat)
   );

   tlp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (stage_valid),
      .in_ready      (stage_ready),
      .in_beat       (stage_beat),
      .local_address (local_address_ff),
      .local_port    (local_port_ff),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_beat      (rsp_beat)
   );

   // pack the result beat, first field lowest
   assign rsp_tuser = rsp_beat.kind;
   assign rsp_tdata = {5'b00000,
                       rsp_beat.range_last,
                       rsp_beat.last_given,
                       rsp_beat.range_first,
                       rsp_beat.range_given,
                       rsp_beat.req_type,
                       rsp_beat.status,
                       rsp_beat.path_byte};

`ifndef SYNTH
   // a path beat never carries a status or range
   a_path_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_PATH)) |->
      ((rsp_beat.status == ST_OK) && !rsp_beat.range_given && !rsp_beat.last_given))
      else $error("path beat with status or range");

   // a failed request reports no range
   a_fail_no_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_beat.status != ST_OK)) |->
      (!rsp_beat.range_given && !rsp_beat.last_given &&
       (rsp_beat.range_first == '0) && (rsp_beat.range_last == '0)))
      else $error("range reported on failed request");

   // a range end is only given with a range start
   a_last_needs_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_beat.last_given) |-> rsp_beat.range_given)
      else $error("range end without range start");

   // only GET requests carry a range
   a_range_get_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_beat.range_given) |-> !rsp_beat.req_type)
      else $error("range on INF request");
`endif

endmodule
